@@ design/rhc_pkg.sv @@
package rhc_pkg;

	localparam int CHAN_W = 8;
	localparam int QUO_W  = 16;
	localparam int SAT_W  = 8;
	localparam int REM_W  = 11;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] mx;
		logic [CHAN_W-1:0] mn;
	} pix_sort_t;

	typedef struct packed {
		logic [SAT_W-1:0] sat_rem;
		logic [SAT_W-1:0] sat_den;
		logic [QUO_W-1:0] sat_num;
		logic [QUO_W-1:0] sat_quo;
		logic [REM_W-1:0] hue_rem;
		logic [REM_W-1:0] hue_div;
		logic [QUO_W-1:0] hue_quo;
		logic [QUO_W-1:0] light;
	} div_work_t;

	// One restoring division step: the MSB of the result is the quotient bit.
	function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
		input logic [REM_W-1:0] div, input logic nbit);
		logic [REM_W:0] trial;
		logic [REM_W:0] diff;
		trial = {rem, nbit};
		diff  = trial - {1'b0, div};
		if (trial >= {1'b0, div}) begin
			return {1'b1, diff[REM_W-1:0]};
		end
		return {1'b0, trial[REM_W-1:0]};
	endfunction

endpackage

@@ design/rgb_to_hsl_convert_unit.sv @@
// Channel | Valid / Ready          | Fields
// pixel   | pix_valid / pix_ready  | red, green, blue (8 bits each)
// HSL     | hsl_valid / hsl_ready  | hue, saturation, lightness (16 bits each)
//
// One pixel is accepted per cycle unless a stall at the HSL output backs up the pipeline.
// Two sort and prepare stages feed a chain of restoring division stages that
// produce the saturation and hue quotients side by side.
// Reset clears only the valid bits of each stage.
// A stage holds its transaction only while the next stage is full and stalled,
// so bubbles close up and input is taken while a result waits at the output.
module rgb_to_hsl_convert_unit
	import rhc_pkg::*;
#(
	parameter int STEPS_PER_STAGE = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              hsl_valid,
	input  logic              hsl_ready,
	output logic [QUO_W-1:0]  hue,
	output logic [QUO_W-1:0]  saturation,
	output logic [QUO_W-1:0]  lightness
);

	localparam int NUM_DIV = QUO_W / STEPS_PER_STAGE;

	pix_sort_t sort_c;
	pix_sort_t pix_s1;
	logic      valid_s1;
	logic      ready_s1;

	div_work_t prep_c;
	div_work_t work_s2;
	logic      valid_s2;

	logic      chain_valid [NUM_DIV+1];
	logic      chain_ready [NUM_DIV+1];
	div_work_t chain_data  [NUM_DIV+1];

	always_comb begin : sort
		logic [CHAN_W-1:0] hi_rg;
		logic [CHAN_W-1:0] lo_rg;
		hi_rg = (red > green) ? red : green;
		lo_rg = (red < green) ? red : green;
		sort_c.red   = red;
		sort_c.green = green;
		sort_c.blue  = blue;
		sort_c.mx    = (hi_rg > blue) ? hi_rg : blue;
		sort_c.mn    = (lo_rg < blue) ? lo_rg : blue;
	end

	assign pix_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			pix_s1 <= sort_c;
		end
	end

	always_comb begin : prep
		logic [CHAN_W-1:0] d;
		logic [CHAN_W:0]   sum;
		logic [CHAN_W:0]   den;
		logic [REM_W-1:0]  d_x;
		logic [REM_W-1:0]  d6;
		logic [REM_W-1:0]  hn;
		logic [23:0]       num;
		logic [16:0]       light_x;
		d       = pix_s1.mx - pix_s1.mn;
		sum     = {1'b0, pix_s1.mx} + {1'b0, pix_s1.mn};
		den     = (sum <= 9'd255) ? sum : (9'd510 - sum);
		d_x     = {3'b000, d};
		d6      = (d_x << 2) + (d_x << 1);
		num     = {d, 16'h0000} - {16'h0000, d};
		light_x = {sum, 8'h00} + {8'h00, sum};
		if (pix_s1.red == pix_s1.mx) begin
			hn = (pix_s1.green == pix_s1.mn) ?
				(d6 - d_x) + {3'b000, pix_s1.mx - pix_s1.blue} :
				d_x - {3'b000, pix_s1.mx - pix_s1.green};
		end else if (pix_s1.green == pix_s1.mx) begin
			hn = (pix_s1.blue == pix_s1.mn) ?
				d_x + {3'b000, pix_s1.mx - pix_s1.red} :
				(d_x + (d_x << 1)) - {3'b000, pix_s1.mx - pix_s1.blue};
		end else begin
			hn = (pix_s1.red == pix_s1.mn) ?
				(d_x + (d_x << 1)) + {3'b000, pix_s1.mx - pix_s1.green} :
				(d6 - d_x) - {3'b000, pix_s1.mx - pix_s1.red};
		end
		if (hn >= d6) begin
			hn = '0;
		end
		prep_c.sat_quo = '0;
		prep_c.hue_quo = '0;
		prep_c.light   = light_x[16:1];
		// A grey pixel divides zero by one, so both quotients come out zero.
		if (d == '0) begin
			prep_c.sat_rem = '0;
			prep_c.sat_den = SAT_W'(1);
			prep_c.sat_num = '0;
			prep_c.hue_rem = '0;
			prep_c.hue_div = REM_W'(1);
		end else begin
			prep_c.sat_rem = num[23:16];
			prep_c.sat_den = den[SAT_W-1:0];
			prep_c.sat_num = num[15:0];
			prep_c.hue_rem = hn;
			prep_c.hue_div = d6;
		end
	end

	assign ready_s1 = !valid_s2 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			work_s2 <= prep_c;
		end
	end

	assign chain_valid[0] = valid_s2;
	assign chain_data[0]  = work_s2;

	for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
		rhc_div_stage #(
			.STEPS(STEPS_PER_STAGE)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[k]),
			.in_ready (chain_ready[k]),
			.in_data  (chain_data[k]),
			.out_valid(chain_valid[k+1]),
			.out_ready(chain_ready[k+1]),
			.out_data (chain_data[k+1])
		);
	end

	assign chain_ready[NUM_DIV] = hsl_ready;
	assign hsl_valid  = chain_valid[NUM_DIV];
	assign hue        = chain_data[NUM_DIV].hue_quo;
	assign saturation = chain_data[NUM_DIV].sat_quo;
	assign lightness  = chain_data[NUM_DIV].light;

	a_sort_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (pix_s1.mx >= pix_s1.mn) &&
			((pix_s1.mx == pix_s1.red) || (pix_s1.mx == pix_s1.green) ||
			(pix_s1.mx == pix_s1.blue)))
		else $error("sorted extremes inconsistent with the pixel");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s1 |=> valid_s1 && $stable(pix_s1))
		else $error("first stage lost a stalled transaction");

	a_divisors_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (work_s2.sat_den != '0) && (work_s2.hue_div != '0))
		else $error("zero divisor entered the division chain");

	a_grey_hue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && (saturation == '0) |-> (hue == '0))
		else $error("zero saturation with nonzero hue");

endmodule

@@ design/rhc_div_stage.sv @@
module rhc_div_stage
	import rhc_pkg::*;
#(
	parameter int STEPS = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_work_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output div_work_t out_data
);

	localparam int PAD_W = REM_W - SAT_W;

	div_work_t nxt;
	logic      valid_q;
	div_work_t data_q;

	always_comb begin : steps
		logic [REM_W:0] sr;
		logic [REM_W:0] hr;
		nxt = in_data;
		for (int i = 0; i < STEPS; i++) begin
			sr = div_step({{PAD_W{1'b0}}, nxt.sat_rem}, {{PAD_W{1'b0}}, nxt.sat_den},
				nxt.sat_num[QUO_W-1]);
			nxt.sat_rem = sr[SAT_W-1:0];
			nxt.sat_quo = {nxt.sat_quo[QUO_W-2:0], sr[REM_W]};
			nxt.sat_num = {nxt.sat_num[QUO_W-2:0], 1'b0};
			hr = div_step(nxt.hue_rem, nxt.hue_div, 1'b0);
			nxt.hue_rem = hr[REM_W-1:0];
			nxt.hue_quo = {nxt.hue_quo[QUO_W-2:0], hr[REM_W]};
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (data_q.sat_rem < data_q.sat_den) && (data_q.hue_rem < data_q.hue_div))
		else $error("partial remainder not below its divisor");

endmodule
